@@ src/rnwc_pkg.sv @@
package rnwc_pkg;

    // Fixed field widths.
    localparam int RAW_W      = 12;
    localparam int WEIGHT_W   = 16;
    localparam int SPEED_W    = 16;
    localparam int FACTOR_W   = 14;
    localparam int PROD_W     = WEIGHT_W + FACTOR_W;
    localparam int FF_W       = 34;
    localparam int TERM_W     = 26;
    localparam int REC_W      = WEIGHT_W + TERM_W;
    localparam int SUM_W      = 50;

    // Weight store and configuration map.
    localparam int WEIGHT_TOTAL     = 24;
    localparam int WEIGHTS_PER_REG  = 4;
    localparam int WEIGHT_BANKS     = WEIGHT_TOTAL / WEIGHTS_PER_REG;
    localparam int CFG_DATA_W       = 64;
    localparam int CFG_ADDR_W       = 6;
    localparam int CFG_INDEX_LSB    = 3;
    localparam int CFG_INDEX_W      = CFG_ADDR_W - CFG_INDEX_LSB;
    localparam int PROX_COUNT       = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_WEIGHTS_LAST = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD    = 3'd6;

    localparam logic [RAW_W-1:0] THRESHOLD_RESET = 12'd800;

    // Neutral point of a unit input: 512 in input units.
    localparam logic signed [FACTOR_W-1:0] FACTOR_BASE   = 14'sd512;
    localparam logic signed [FACTOR_W-1:0] FACTOR_GROUND = 14'sd513;

    // 1.0 at the recurrent scale of 2^-24.
    localparam logic signed [TERM_W-1:0] REC_BASE = 26'sd16777216;

    // Tanh table geometry: segments of 1/8 at bit 33, fraction below it.
    localparam int TANH_SEG_LSB  = 33;
    localparam int TANH_FRAC_LSB = 17;
    localparam int TANH_FRAC_W   = TANH_SEG_LSB - TANH_FRAC_LSB;
    localparam int TANH_SEG_W    = SUM_W - TANH_SEG_LSB;
    localparam int TANH_IDX_W    = 6;
    localparam int TANH_SEGMENTS = 40;
    localparam int TANH_Y_W      = 15;
    localparam logic [SPEED_W-1:0] OUT_MAX = 16'd32767;

    typedef logic signed [WEIGHT_W-1:0] weight_t;

    typedef struct packed {
        weight_t self_left;
        weight_t cross_left;
        weight_t self_right;
        weight_t cross_right;
    } rec_weights_t;

    // round(32768 * tanh(k / 8)) for k = 0..40.
    function automatic logic [TANH_Y_W-1:0] tanh_lut(input logic [TANH_IDX_W-1:0] k);
        logic [TANH_Y_W-1:0] y;
        case (k)
            6'd0:  y = 15'd0;
            6'd1:  y = 15'd4075;
            6'd2:  y = 15'd8025;
            6'd3:  y = 15'd11743;
            6'd4:  y = 15'd15143;
            6'd5:  y = 15'd18173;
            6'd6:  y = 15'd20813;
            6'd7:  y = 15'd23066;
            6'd8:  y = 15'd24956;
            6'd9:  y = 15'd26519;
            6'd10: y = 15'd27797;
            6'd11: y = 15'd28830;
            6'd12: y = 15'd29660;
            6'd13: y = 15'd30322;
            6'd14: y = 15'd30847;
            6'd15: y = 15'd31262;
            6'd16: y = 15'd31589;
            6'd17: y = 15'd31846;
            6'd18: y = 15'd32048;
            6'd19: y = 15'd32206;
            6'd20: y = 15'd32329;
            6'd21: y = 15'd32426;
            6'd22: y = 15'd32501;
            6'd23: y = 15'd32560;
            6'd24: y = 15'd32606;
            6'd25: y = 15'd32642;
            6'd26: y = 15'd32670;
            6'd27: y = 15'd32691;
            6'd28: y = 15'd32708;
            6'd29: y = 15'd32721;
            6'd30: y = 15'd32732;
            6'd31: y = 15'd32740;
            6'd32: y = 15'd32746;
            6'd33: y = 15'd32751;
            6'd34: y = 15'd32755;
            6'd35: y = 15'd32758;
            6'd36: y = 15'd32760;
            6'd37: y = 15'd32762;
            6'd38: y = 15'd32763;
            6'd39: y = 15'd32764;
            6'd40: y = 15'd32765;
            default: y = 15'd0;
        endcase
        return y;
    endfunction

endpackage

@@ src/rnwc_ifs.sv @@
interface rnwc_sample_if;
    logic                         valid;
    logic                         ready;
    logic [rnwc_pkg::RAW_W-1:0]   prox_0;
    logic [rnwc_pkg::RAW_W-1:0]   prox_1;
    logic [rnwc_pkg::RAW_W-1:0]   prox_2;
    logic [rnwc_pkg::RAW_W-1:0]   prox_3;
    logic [rnwc_pkg::RAW_W-1:0]   prox_4;
    logic [rnwc_pkg::RAW_W-1:0]   prox_5;
    logic [rnwc_pkg::RAW_W-1:0]   prox_6;
    logic [rnwc_pkg::RAW_W-1:0]   prox_7;
    logic [rnwc_pkg::RAW_W-1:0]   ground_left;
    logic [rnwc_pkg::RAW_W-1:0]   ground_right;

    modport source (
        output valid, prox_0, prox_1, prox_2, prox_3, prox_4, prox_5, prox_6, prox_7,
               ground_left, ground_right,
        input  ready
    );
    modport sink (
        input  valid, prox_0, prox_1, prox_2, prox_3, prox_4, prox_5, prox_6, prox_7,
               ground_left, ground_right,
        output ready
    );
endinterface

interface rnwc_drive_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [rnwc_pkg::SPEED_W-1:0]  speed_left;
    logic signed [rnwc_pkg::SPEED_W-1:0]  speed_right;

    modport source (
        output valid, speed_left, speed_right,
        input  ready
    );
    modport sink (
        input  valid, speed_left, speed_right,
        output ready
    );
endinterface

@@ src/rnwc_lane.sv @@
// One sensor row: forms the input factor and multiplies it by both wheel weights.
module rnwc_lane (
    input  logic                                  clk,
    input  logic                                  load,
    input  logic                                  ground_row,
    input  logic [rnwc_pkg::RAW_W-1:0]            raw,
    input  logic [rnwc_pkg::RAW_W-1:0]            threshold,
    input  rnwc_pkg::weight_t                     weight_left,
    input  rnwc_pkg::weight_t                     weight_right,
    output logic signed [rnwc_pkg::PROD_W-1:0]    prod_left,
    output logic signed [rnwc_pkg::PROD_W-1:0]    prod_right
);

    logic signed [rnwc_pkg::FACTOR_W-1:0] factor;
    logic signed [rnwc_pkg::PROD_W-1:0]   prod_left_reg;
    logic signed [rnwc_pkg::PROD_W-1:0]   prod_right_reg;
    logic signed [rnwc_pkg::PROD_W-1:0]   prod_left_next;
    logic signed [rnwc_pkg::PROD_W-1:0]   prod_right_next;

    // A ground reading above the threshold counts as -1, giving 513 instead of 512.
    always_comb
    begin
        if (ground_row)
        begin
            factor = (raw > threshold) ? rnwc_pkg::FACTOR_GROUND : rnwc_pkg::FACTOR_BASE;
        end
        else
        begin
            factor = rnwc_pkg::FACTOR_BASE - $signed({2'b00, raw});
        end
        prod_left_next  = weight_left * factor;
        prod_right_next = weight_right * factor;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_left_reg  <= prod_left_next;
            prod_right_reg <= prod_right_next;
        end
    end

    assign prod_left  = prod_left_reg;
    assign prod_right = prod_right_reg;

endmodule

@@ src/rnwc_merge.sv @@
// Adds the row products of all lanes into one feed-forward sum per wheel.
module rnwc_merge #(
    parameter int LANES = 10
) (
    input  logic                                  clk,
    input  logic                                  load,
    input  logic signed [rnwc_pkg::PROD_W-1:0]    prod_left  [LANES],
    input  logic signed [rnwc_pkg::PROD_W-1:0]    prod_right [LANES],
    output logic signed [rnwc_pkg::FF_W-1:0]      ff_left,
    output logic signed [rnwc_pkg::FF_W-1:0]      ff_right
);

    logic signed [rnwc_pkg::FF_W-1:0] ff_left_next;
    logic signed [rnwc_pkg::FF_W-1:0] ff_right_next;
    logic signed [rnwc_pkg::FF_W-1:0] ff_left_reg;
    logic signed [rnwc_pkg::FF_W-1:0] ff_right_reg;

    always_comb
    begin
        ff_left_next  = '0;
        ff_right_next = '0;
        for (int i = 0; i < LANES; i++)
        begin
            ff_left_next  = ff_left_next  + rnwc_pkg::FF_W'(prod_left[i]);
            ff_right_next = ff_right_next + rnwc_pkg::FF_W'(prod_right[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ff_left_reg  <= ff_left_next;
            ff_right_reg <= ff_right_next;
        end
    end

    assign ff_left  = ff_left_reg;
    assign ff_right = ff_right_reg;

endmodule

@@ src/rnwc_recur.sv @@
// Recurrent loop: adds the terms from the previous outputs, then tanh with interpolation.
// One pass steps through MUL, SUM, MAG and FIN; FIN also takes the next feed-forward sum.
module rnwc_recur (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  ff_valid,
    input  logic signed [rnwc_pkg::FF_W-1:0]      ff_left,
    input  logic signed [rnwc_pkg::FF_W-1:0]      ff_right,
    output logic                                  ff_take,
    input  rnwc_pkg::rec_weights_t                weights,
    input  logic                                  slot_free,
    output logic                                  done,
    output logic signed [rnwc_pkg::SPEED_W-1:0]   speed_left,
    output logic signed [rnwc_pkg::SPEED_W-1:0]   speed_right
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_MUL  = 5'b00010,
        ST_SUM  = 5'b00100,
        ST_MAG  = 5'b01000,
        ST_FIN  = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Index 0 is the left wheel, index 1 the right wheel.
    logic signed [rnwc_pkg::SPEED_W-1:0]     prev_reg  [2];
    logic signed [rnwc_pkg::SPEED_W-1:0]     prev_next [2];
    logic signed [rnwc_pkg::FF_W-1:0]        ff_reg    [2];
    logic signed [rnwc_pkg::REC_W-1:0]       rs_reg    [2];
    logic signed [rnwc_pkg::REC_W-1:0]       rc_reg    [2];
    logic signed [rnwc_pkg::REC_W-1:0]       rs_next   [2];
    logic signed [rnwc_pkg::REC_W-1:0]       rc_next   [2];
    logic signed [rnwc_pkg::SUM_W-1:0]       sum_reg   [2];
    logic signed [rnwc_pkg::SUM_W-1:0]       sum_next  [2];
    logic [1:0]                              neg_reg;
    logic [1:0]                              neg_next;
    logic [1:0]                              sat_reg;
    logic [1:0]                              sat_next;
    logic [rnwc_pkg::TANH_Y_W-1:0]           base_reg  [2];
    logic [rnwc_pkg::TANH_Y_W-1:0]           base_next [2];
    logic [rnwc_pkg::TANH_Y_W-1:0]           diff_reg  [2];
    logic [rnwc_pkg::TANH_Y_W-1:0]           diff_next [2];
    logic [rnwc_pkg::TANH_FRAC_W-1:0]        frac_reg  [2];
    logic [rnwc_pkg::TANH_FRAC_W-1:0]        frac_next [2];

    logic signed [rnwc_pkg::WEIGHT_W-1:0]    w_self    [2];
    logic signed [rnwc_pkg::WEIGHT_W-1:0]    w_cross   [2];
    logic signed [rnwc_pkg::TERM_W-1:0]      self_term [2];
    logic signed [rnwc_pkg::TERM_W-1:0]      cross_term[2];
    logic [rnwc_pkg::SUM_W-1:0]              mag       [2];
    logic [rnwc_pkg::TANH_SEG_W-1:0]         seg       [2];
    logic [rnwc_pkg::TANH_IDX_W-1:0]         seg_idx   [2];
    logic [2*rnwc_pkg::TANH_FRAC_W-1:0]      interp    [2];
    logic [2*rnwc_pkg::TANH_FRAC_W:0]        interp_rnd[2];
    logic [rnwc_pkg::TANH_FRAC_W:0]          y_full    [2];
    logic [rnwc_pkg::SPEED_W-1:0]            y_mag     [2];

    assign w_self[0]  = weights.self_left;
    assign w_cross[0] = weights.cross_left;
    assign w_self[1]  = weights.self_right;
    assign w_cross[1] = weights.cross_right;

    always_comb
    begin
        done    = (state_reg == ST_FIN) && slot_free;
        ff_take = ff_valid && ((state_reg == ST_IDLE) || done);

        case (state_reg)
            ST_IDLE: state_next = ff_valid ? ST_MUL : ST_IDLE;
            ST_MUL:  state_next = ST_SUM;
            ST_SUM:  state_next = ST_MAG;
            ST_MAG:  state_next = ST_FIN;
            ST_FIN:
            begin
                if (slot_free)
                begin
                    state_next = ff_valid ? ST_MUL : ST_IDLE;
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        for (int w = 0; w < 2; w++)
        begin
            // Recurrent factor is 1 - p/512 in Q24, with p the previous Q1.15 output.
            self_term[w]  = rnwc_pkg::REC_BASE
                          - rnwc_pkg::TERM_W'(prev_reg[w]);
            cross_term[w] = rnwc_pkg::REC_BASE
                          - rnwc_pkg::TERM_W'(prev_reg[1-w]);
            rs_next[w] = w_self[w] * self_term[w];
            rc_next[w] = w_cross[w] * cross_term[w];

            // Feed-forward sum moves from scale 2^-21 to 2^-36.
            sum_next[w] = {{(rnwc_pkg::SUM_W-rnwc_pkg::FF_W-15){ff_reg[w][rnwc_pkg::FF_W-1]}},
                           ff_reg[w], 15'b0}
                        + rnwc_pkg::SUM_W'(rs_reg[w])
                        + rnwc_pkg::SUM_W'(rc_reg[w]);

            neg_next[w] = sum_reg[w][rnwc_pkg::SUM_W-1];
            mag[w]      = neg_next[w] ? rnwc_pkg::SUM_W'(-sum_reg[w])
                                      : rnwc_pkg::SUM_W'(sum_reg[w]);
            seg[w]      = mag[w][rnwc_pkg::SUM_W-1:rnwc_pkg::TANH_SEG_LSB];
            sat_next[w] = seg[w] >= rnwc_pkg::TANH_SEG_W'(rnwc_pkg::TANH_SEGMENTS);
            seg_idx[w]  = seg[w][rnwc_pkg::TANH_IDX_W-1:0];
            frac_next[w] = mag[w][rnwc_pkg::TANH_SEG_LSB-1:rnwc_pkg::TANH_FRAC_LSB];
            base_next[w] = rnwc_pkg::tanh_lut(seg_idx[w]);
            diff_next[w] = rnwc_pkg::tanh_lut(seg_idx[w] + 6'd1) - base_next[w];

            // Linear interpolation, rounding half up.
            interp[w]     = (2*rnwc_pkg::TANH_FRAC_W)'(diff_reg[w]) * 
                            (2*rnwc_pkg::TANH_FRAC_W)'(frac_reg[w]);
            interp_rnd[w] = {1'b0, interp[w]} + (2*rnwc_pkg::TANH_FRAC_W+1)'(32768);
            y_full[w]     = (rnwc_pkg::TANH_FRAC_W+1)'(base_reg[w])
                          + interp_rnd[w][2*rnwc_pkg::TANH_FRAC_W:rnwc_pkg::TANH_FRAC_W];
            if (sat_reg[w] || (y_full[w] > (rnwc_pkg::TANH_FRAC_W+1)'(rnwc_pkg::OUT_MAX)))
            begin
                y_mag[w] = rnwc_pkg::OUT_MAX;
            end
            else
            begin
                y_mag[w] = y_full[w][rnwc_pkg::SPEED_W-1:0];
            end
            prev_next[w] = neg_reg[w] ? -$signed(y_mag[w]) : $signed(y_mag[w]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            prev_reg[0] <= '0;
            prev_reg[1] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (done)
            begin
                prev_reg[0] <= prev_next[0];
                prev_reg[1] <= prev_next[1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ff_take)
        begin
            ff_reg[0] <= ff_left;
            ff_reg[1] <= ff_right;
        end
        for (int w = 0; w < 2; w++)
        begin
            if (state_reg == ST_MUL)
            begin
                rs_reg[w] <= rs_next[w];
                rc_reg[w] <= rc_next[w];
            end
            if (state_reg == ST_SUM)
            begin
                sum_reg[w] <= sum_next[w];
            end
            if (state_reg == ST_MAG)
            begin
                neg_reg[w]  <= neg_next[w];
                sat_reg[w]  <= sat_next[w];
                base_reg[w] <= base_next[w];
                diff_reg[w] <= diff_next[w];
                frac_reg[w] <= frac_next[w];
            end
        end
    end

    assign speed_left  = prev_next[0];
    assign speed_right = prev_next[1];

endmodule

@@ src/recurrent_neural_wheel_controller.sv @@
// Channel   Dir   Beat contents                                   Accepted when
// sample    in    prox_0..prox_7, ground_left, ground_right       valid && ready
// drive     out   speed_left, speed_right (Q1.15)                 valid && ready
// apb       in    psel/penable/pwrite/paddr/pwdata, prdata        psel && penable && pwrite
//
// A sample beat is taken in the lane stage, summed in the merge stage, and then passes
// through the recurrent loop (multiply, add, magnitude and table lookup, interpolation);
// each output feeds the next sum, so the loop takes a new beat only as the last one finishes.
// Reset clears the handshake state, previous outputs and weights; the threshold is 800.
// A stalled drive beat holds in the output register while the earlier stages fill up.
module recurrent_neural_wheel_controller #(
    parameter int SENSOR_COUNT = 10
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    rnwc_sample_if.sink                            sample,
    rnwc_drive_if.source                           drive,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [rnwc_pkg::CFG_ADDR_W-1:0]        paddr,
    input  logic [rnwc_pkg::CFG_DATA_W-1:0]        pwdata,
    output logic [rnwc_pkg::CFG_DATA_W-1:0]        prdata,
    output logic                                   pready
);

    localparam int PROX_ROWS = SENSOR_COUNT - 2;

    // ------------------------------------------------------------------
    // Configuration registers. The weight store is flat: weight row*2+wheel.
    // ------------------------------------------------------------------
    logic [rnwc_pkg::WEIGHT_W-1:0]    weights_reg [rnwc_pkg::WEIGHT_TOTAL];
    logic [rnwc_pkg::RAW_W-1:0]       threshold_reg;
    logic [rnwc_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic                             cfg_write;
    logic [rnwc_pkg::CFG_DATA_W-1:0]  bank [rnwc_pkg::WEIGHT_BANKS];

    assign pready    = 1'b1;
    assign cfg_index = paddr[rnwc_pkg::CFG_ADDR_W-1:rnwc_pkg::CFG_INDEX_LSB];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < rnwc_pkg::WEIGHT_TOTAL; j++)
            begin
                weights_reg[j] <= '0;
            end
            threshold_reg <= rnwc_pkg::THRESHOLD_RESET;
        end
        else if (cfg_write)
        begin
            // Each weight register carries four weights, lowest flat index in the low lane.
            for (int j = 0; j < rnwc_pkg::WEIGHT_TOTAL; j++)
            begin
                if ((cfg_index <= rnwc_pkg::REG_WEIGHTS_LAST)
                    && (cfg_index == rnwc_pkg::CFG_INDEX_W'(j / 4)))
                begin
                    weights_reg[j] <= pwdata[rnwc_pkg::WEIGHT_W*(j % 4) +: rnwc_pkg::WEIGHT_W];
                end
            end
            if (cfg_index == rnwc_pkg::REG_THRESHOLD)
            begin
                threshold_reg <= pwdata[rnwc_pkg::RAW_W-1:0];
            end
        end
    end

    for (genvar b = 0; b < rnwc_pkg::WEIGHT_BANKS; b++)
    begin : g_bank
        assign bank[b] = {weights_reg[4*b+3], weights_reg[4*b+2],
                          weights_reg[4*b+1], weights_reg[4*b]};
    end

    always_comb
    begin
        prdata = '0;
        if (cfg_index <= rnwc_pkg::REG_WEIGHTS_LAST)
        begin
            prdata = bank[cfg_index];
        end
        else if (cfg_index == rnwc_pkg::REG_THRESHOLD)
        begin
            prdata = rnwc_pkg::CFG_DATA_W'(threshold_reg);
        end
    end

    // ------------------------------------------------------------------
    // Handshake through the lane and merge stages. A stage moves on when the
    // one after it is empty or emptying in the same cycle.
    // ------------------------------------------------------------------
    logic lane_valid_reg;
    logic lane_valid_next;
    logic merge_valid_reg;
    logic merge_valid_next;
    logic sample_take;
    logic merge_load;
    logic ff_take;

    assign merge_load   = lane_valid_reg && (!merge_valid_reg || ff_take);
    assign sample.ready = !lane_valid_reg || merge_load;
    assign sample_take  = sample.valid && sample.ready;

    always_comb
    begin
        lane_valid_next  = sample_take || (lane_valid_reg && !merge_load);
        merge_valid_next = merge_load || (merge_valid_reg && !ff_take);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lane_valid_reg  <= 1'b0;
            merge_valid_reg <= 1'b0;
        end
        else
        begin
            lane_valid_reg  <= lane_valid_next;
            merge_valid_reg <= merge_valid_next;
        end
    end

    // ------------------------------------------------------------------
    // Lanes: one per sensor row. The last two rows read the ground sensors.
    // ------------------------------------------------------------------
    logic [rnwc_pkg::RAW_W-1:0]            prox_arr   [rnwc_pkg::PROX_COUNT];
    logic signed [rnwc_pkg::PROD_W-1:0]    prod_left  [SENSOR_COUNT];
    logic signed [rnwc_pkg::PROD_W-1:0]    prod_right [SENSOR_COUNT];

    assign prox_arr[0] = sample.prox_0;
    assign prox_arr[1] = sample.prox_1;
    assign prox_arr[2] = sample.prox_2;
    assign prox_arr[3] = sample.prox_3;
    assign prox_arr[4] = sample.prox_4;
    assign prox_arr[5] = sample.prox_5;
    assign prox_arr[6] = sample.prox_6;
    assign prox_arr[7] = sample.prox_7;

    for (genvar r = 0; r < SENSOR_COUNT; r++)
    begin : g_lane
        logic [rnwc_pkg::RAW_W-1:0] raw;
        logic                       ground_row;

        if (r < PROX_ROWS)
        begin : g_prox
            assign raw        = prox_arr[r];
            assign ground_row = 1'b0;
        end
        else if (r == PROX_ROWS)
        begin : g_ground_left
            assign raw        = sample.ground_left;
            assign ground_row = 1'b1;
        end
        else
        begin : g_ground_right
            assign raw        = sample.ground_right;
            assign ground_row = 1'b1;
        end

        rnwc_lane u_lane (
            .clk          (clk),
            .load         (sample_take),
            .ground_row   (ground_row),
            .raw          (raw),
            .threshold    (threshold_reg),
            .weight_left  (weights_reg[2*r]),
            .weight_right (weights_reg[2*r+1]),
            .prod_left    (prod_left[r]),
            .prod_right   (prod_right[r])
        );
    end

    // ------------------------------------------------------------------
    // Merge stage: feed-forward sum per wheel.
    // ------------------------------------------------------------------
    logic signed [rnwc_pkg::FF_W-1:0] ff_left;
    logic signed [rnwc_pkg::FF_W-1:0] ff_right;

    rnwc_merge #(
        .LANES (SENSOR_COUNT)
    ) u_merge (
        .clk        (clk),
        .load       (merge_load),
        .prod_left  (prod_left),
        .prod_right (prod_right),
        .ff_left    (ff_left),
        .ff_right   (ff_right)
    );

    // ------------------------------------------------------------------
    // Recurrent loop. Its weight rows follow the sensor rows.
    // ------------------------------------------------------------------
    rnwc_pkg::rec_weights_t             rec_weights;
    logic                               slot_free;
    logic                               rec_done;
    logic signed [rnwc_pkg::SPEED_W-1:0] rec_left;
    logic signed [rnwc_pkg::SPEED_W-1:0] rec_right;

    assign rec_weights.self_left   = weights_reg[2*SENSOR_COUNT];
    assign rec_weights.self_right  = weights_reg[2*SENSOR_COUNT+1];
    assign rec_weights.cross_left  = weights_reg[2*SENSOR_COUNT+2];
    assign rec_weights.cross_right = weights_reg[2*SENSOR_COUNT+3];

    rnwc_recur u_recur (
        .clk         (clk),
        .rst_n       (rst_n),
        .ff_valid    (merge_valid_reg),
        .ff_left     (ff_left),
        .ff_right    (ff_right),
        .ff_take     (ff_take),
        .weights     (rec_weights),
        .slot_free   (slot_free),
        .done        (rec_done),
        .speed_left  (rec_left),
        .speed_right (rec_right)
    );

    // ------------------------------------------------------------------
    // Output register. The loop finishes only into a free or emptying slot.
    // ------------------------------------------------------------------
    logic                                out_valid_reg;
    logic                                out_valid_next;
    logic signed [rnwc_pkg::SPEED_W-1:0] speed_left_reg;
    logic signed [rnwc_pkg::SPEED_W-1:0] speed_right_reg;

    assign slot_free      = !out_valid_reg || drive.ready;
    assign out_valid_next = rec_done || (out_valid_reg && !drive.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rec_done)
        begin
            speed_left_reg  <= rec_left;
            speed_right_reg <= rec_right;
        end
    end

    assign drive.valid       = out_valid_reg;
    assign drive.speed_left  = speed_left_reg;
    assign drive.speed_right = speed_right_reg;

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps

// Testbench for the recurrent wheel controller.
//
// Sample beats go in through the sample channel and one drive beat (a speed
// for each wheel) comes out per sample.  The bench keeps its own copy of the
// weight bank, the ground threshold and the two previous wheel speeds.  It
// predicts each drive beat when the matching sample beat is accepted and
// checks the drive beats in order.
//
// The run starts with a short directed part:
// - zero weights after reset,
// - all weights at the positive and negative extremes so the sum runs into
//   the large sum clip,
// - ground readings on both sides of the threshold.
// Then it steps through several random weight scales and thresholds.
// Both channels idle at random.  Once the receiver holds off for a long
// stretch so that the pipeline fills up and stalls the sample channel.
// Once the sender pauses in mid phase until every drive beat is back.
module tb;

    localparam int RESET_CYCLES   = 8;
    localparam int PHASE_COUNT    = 8;
    localparam int PHASE_ITEMS    = 210;
    localparam int LONG_HOLD      = 400;
    localparam int STUCK_LIMIT    = 5000;
    localparam int SETTLE_CYCLES  = 24;
    localparam int REG_UNUSED     = 7;
    localparam int RAW_MAX        = 4095;
    localparam int SPEED_MAX      = 32767;

    // round(32768 * tanh(k / 8)) for k = 0..40, the knots of the tanh curve.
    localparam int TANH_POINTS [0:40] = '{
        0, 4075, 8025, 11743, 15143, 18173, 20813, 23066,
        24956, 26519, 27797, 28830, 29660, 30322, 30847, 31262,
        31589, 31846, 32048, 32206, 32329, 32426, 32501, 32560,
        32606, 32642, 32670, 32691, 32708, 32721, 32732, 32740,
        32746, 32751, 32755, 32758, 32760, 32762, 32763, 32764,
        32765
    };

    typedef struct packed {
        logic [rnwc_pkg::PROX_COUNT-1:0][rnwc_pkg::RAW_W-1:0] prox;
        logic [rnwc_pkg::RAW_W-1:0]                           ground_left;
        logic [rnwc_pkg::RAW_W-1:0]                           ground_right;
    } sample_t;

    typedef struct packed {
        logic signed [rnwc_pkg::SPEED_W-1:0] left;
        logic signed [rnwc_pkg::SPEED_W-1:0] right;
    } speed_pair_t;

    logic                             clk;
    logic                             rst_n;
    logic                             psel;
    logic                             penable;
    logic                             pwrite;
    logic [rnwc_pkg::CFG_ADDR_W-1:0]  paddr;
    logic [rnwc_pkg::CFG_DATA_W-1:0]  pwdata;
    logic [rnwc_pkg::CFG_DATA_W-1:0]  prdata;
    logic                             pready;

    rnwc_sample_if smp ();
    rnwc_drive_if  drv ();

    recurrent_neural_wheel_controller dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .sample  (smp),
        .drive   (drv),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow of the block's configuration and recurrent state.
    rnwc_pkg::weight_t                   weight_bank [rnwc_pkg::WEIGHT_TOTAL];
    logic [rnwc_pkg::RAW_W-1:0]          ground_limit;
    logic signed [rnwc_pkg::SPEED_W-1:0] prev_left;
    logic signed [rnwc_pkg::SPEED_W-1:0] prev_right;

    sample_t     pending_samples [$];
    speed_pair_t expected_speeds [$];
    int          errors;

    // Sender state.  The gap is drawn per beat, and a run of beats is either
    // quiet (back to back) or idles at random.
    sample_t tx_item;
    bit      tx_busy;
    int      tx_gap;
    int      tx_run;
    bit      tx_quiet;

    // Receiver state, built the same way.
    int      rx_stall;
    int      rx_run;
    bit      rx_quiet;

    // Long receiver hold-off: the stimulus bumps the request count and the
    // hold process below serves it.
    int      hold_requests;
    int      hold_granted;
    int      hold_left;

    int      stuck_cycles;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Interpolated tanh of a sum held at scale 2^-36.  The magnitude is cut
    // to steps of 2^-19: bits 33 and up pick the segment of width 1/8 and
    // the 16 bits below them interpolate, rounding half up.  Magnitudes of 5
    // or more clip to full scale.
    function automatic logic signed [rnwc_pkg::SPEED_W-1:0] tanh_speed(input longint sum);
        longint mag;
        longint seg;
        longint frac;
        longint y;
        mag = (sum < 0) ? -sum : sum;
        seg = mag >> rnwc_pkg::TANH_SEG_LSB;
        if (seg >= rnwc_pkg::TANH_SEGMENTS)
        begin
            y = SPEED_MAX;
        end
        else
        begin
            frac = (mag >> rnwc_pkg::TANH_FRAC_LSB) & 64'hFFFF;
            y = TANH_POINTS[int'(seg)]
                + (((TANH_POINTS[int'(seg) + 1] - TANH_POINTS[int'(seg)]) * frac + 32768)
                   >> 16);
            if (y > SPEED_MAX)
                y = SPEED_MAX;
        end
        return rnwc_pkg::SPEED_W'((sum < 0) ? -y : y);
    endfunction

    // Weighted sum for one wheel.  Weight (row, wheel) sits at row*2+wheel.
    // Proximity rows use the factor 512 - x.  A ground row uses 513 when its
    // reading is strictly above the threshold (input -1) and 512 otherwise.
    // The self and cross rows weigh 2^24 minus the previous Q1.15 outputs.
    function automatic logic signed [rnwc_pkg::SPEED_W-1:0] wheel_drive(
        input sample_t                             s,
        input int                                  wheel,
        input logic signed [rnwc_pkg::SPEED_W-1:0] self_prev,
        input logic signed [rnwc_pkg::SPEED_W-1:0] cross_prev
    );
        longint                     acc;
        longint                     factor;
        logic [rnwc_pkg::RAW_W-1:0] g;
        int                         row;
        acc = 0;
        for (row = 0; row < rnwc_pkg::PROX_COUNT; row++)
            acc += longint'(weight_bank[row * 2 + wheel])
                   * (512 - longint'(s.prox[row])) * 32768;
        for (row = rnwc_pkg::PROX_COUNT; row < rnwc_pkg::PROX_COUNT + 2; row++)
        begin
            g = (row == rnwc_pkg::PROX_COUNT) ? s.ground_left : s.ground_right;
            factor = (g > ground_limit) ? 513 : 512;
            acc += longint'(weight_bank[row * 2 + wheel]) * factor * 32768;
        end
        acc += longint'(weight_bank[(rnwc_pkg::PROX_COUNT + 2) * 2 + wheel])
               * (longint'(rnwc_pkg::REC_BASE) - longint'(self_prev));
        acc += longint'(weight_bank[(rnwc_pkg::PROX_COUNT + 3) * 2 + wheel])
               * (longint'(rnwc_pkg::REC_BASE) - longint'(cross_prev));
        return tanh_speed(acc);
    endfunction

    // Works out the drive beat for an accepted sample and advances the
    // recurrent state.
    function automatic void predict_speeds(input sample_t s);
        speed_pair_t p;
        p.left  = wheel_drive(s, 0, prev_left, prev_right);
        p.right = wheel_drive(s, 1, prev_right, prev_left);
        prev_left  = p.left;
        prev_right = p.right;
        expected_speeds.push_back(p);
    endfunction

    function automatic sample_t uniform_sample(
        input logic [rnwc_pkg::RAW_W-1:0] p,
        input logic [rnwc_pkg::RAW_W-1:0] g_left,
        input logic [rnwc_pkg::RAW_W-1:0] g_right
    );
        sample_t s;
        int      k;
        for (k = 0; k < rnwc_pkg::PROX_COUNT; k++)
            s.prox[k] = p;
        s.ground_left  = g_left;
        s.ground_right = g_right;
        return s;
    endfunction

    // Half the ground readings land within two counts of the threshold so
    // that the strict comparison is exercised on both sides.
    function automatic logic [rnwc_pkg::RAW_W-1:0] ground_reading();
        int g;
        if ($urandom_range(0, 1) == 0)
            return rnwc_pkg::RAW_W'($urandom_range(0, RAW_MAX));
        g = int'(ground_limit) + int'($urandom_range(0, 4)) - 2;
        if (g < 0)
            g = 0;
        if (g > RAW_MAX)
            g = RAW_MAX;
        return rnwc_pkg::RAW_W'(g);
    endfunction

    // Proximity readings are either anywhere in range or close to 512, where
    // the factor is near zero and the sums stay on the steep part of tanh.
    function automatic sample_t random_sample();
        sample_t s;
        int      k;
        for (k = 0; k < rnwc_pkg::PROX_COUNT; k++)
            s.prox[k] = ($urandom_range(0, 1) == 0)
                        ? rnwc_pkg::RAW_W'($urandom_range(0, RAW_MAX))
                        : rnwc_pkg::RAW_W'($urandom_range(448, 576));
        s.ground_left  = ground_reading();
        s.ground_right = ground_reading();
        return s;
    endfunction

    // Four random Q4.12 weights shifted down by the given amount, which sets
    // the scale of a phase.
    function automatic logic [rnwc_pkg::CFG_DATA_W-1:0] random_weight_word(input int shift);
        logic [rnwc_pkg::CFG_DATA_W-1:0] word;
        rnwc_pkg::weight_t               lane;
        int                              k;
        for (k = 0; k < rnwc_pkg::WEIGHTS_PER_REG; k++)
        begin
            lane = rnwc_pkg::weight_t'($urandom());
            lane = lane >>> shift;
            word[k * rnwc_pkg::WEIGHT_W +: rnwc_pkg::WEIGHT_W] = lane;
        end
        return word;
    endfunction

    // One write over the configuration port: a setup phase, then an access
    // phase that completes once pready is seen.  The shadow copy follows.
    task automatic write_register(input int index,
                                  input logic [rnwc_pkg::CFG_DATA_W-1:0] value);
        int k;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= rnwc_pkg::CFG_ADDR_W'(index << rnwc_pkg::CFG_INDEX_LSB);
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (index <= int'(rnwc_pkg::REG_WEIGHTS_LAST))
        begin
            for (k = 0; k < rnwc_pkg::WEIGHTS_PER_REG; k++)
                weight_bank[index * rnwc_pkg::WEIGHTS_PER_REG + k] =
                    value[k * rnwc_pkg::WEIGHT_W +: rnwc_pkg::WEIGHT_W];
        end
        else if (index == int'(rnwc_pkg::REG_THRESHOLD))
        begin
            ground_limit = value[rnwc_pkg::RAW_W-1:0];
        end
    endtask

    // The threshold register carries junk in its unused upper bits, which
    // the block must ignore.
    task automatic write_threshold(input logic [rnwc_pkg::RAW_W-1:0] limit);
        logic [rnwc_pkg::CFG_DATA_W-1:0] value;
        value = {$urandom(), $urandom()};
        value[rnwc_pkg::RAW_W-1:0] = limit;
        write_register(int'(rnwc_pkg::REG_THRESHOLD), value);
    endtask

    task automatic write_all_weights(input logic [rnwc_pkg::CFG_DATA_W-1:0] value);
        int i;
        for (i = 0; i <= int'(rnwc_pkg::REG_WEIGHTS_LAST); i++)
            write_register(i, value);
    endtask

    // Returns once the sender has nothing left and every drive beat is back.
    task automatic wait_drained();
        while (pending_samples.size() != 0 || tx_busy || expected_speeds.size() != 0)
            @(posedge clk);
    endtask

    // Sample driver.  At each edge it first books an accepted beat with the
    // predictor, then either counts down its idle gap or picks up the next
    // pending sample.  Valid and the fields each get exactly one assignment.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (smp.valid && smp.ready)
            begin
                predict_speeds(tx_item);
                tx_busy = 1'b0;
                if (tx_run == 0)
                begin
                    tx_quiet = ($urandom_range(0, 2) == 0);
                    tx_run   = $urandom_range(10, 40);
                end
                tx_run--;
                tx_gap = tx_quiet ? 0 : $urandom_range(0, 10);
            end
            if (!tx_busy)
            begin
                if (tx_gap > 0)
                begin
                    tx_gap--;
                end
                else if (pending_samples.size() != 0)
                begin
                    tx_item = pending_samples.pop_front();
                    tx_busy = 1'b1;
                end
            end
            smp.valid        <= tx_busy;
            smp.prox_0       <= tx_item.prox[0];
            smp.prox_1       <= tx_item.prox[1];
            smp.prox_2       <= tx_item.prox[2];
            smp.prox_3       <= tx_item.prox[3];
            smp.prox_4       <= tx_item.prox[4];
            smp.prox_5       <= tx_item.prox[5];
            smp.prox_6       <= tx_item.prox[6];
            smp.prox_7       <= tx_item.prox[7];
            smp.ground_left  <= tx_item.ground_left;
            smp.ground_right <= tx_item.ground_right;
        end
    end

    // Drive monitor.  Every accepted drive beat is compared with the oldest
    // prediction.  After each beat the receiver draws a stall, and a long
    // hold-off keeps ready low on top of that.
    always @(posedge clk)
    begin
        speed_pair_t want;
        if (rst_n)
        begin
            if (drv.valid && drv.ready)
            begin
                if (expected_speeds.size() == 0)
                begin
                    errors++;
                    $error("drive beat with no sample waiting: left %0d right %0d",
                           drv.speed_left, drv.speed_right);
                end
                else
                begin
                    want = expected_speeds.pop_front();
                    if (drv.speed_left !== want.left)
                    begin
                        errors++;
                        $error("speed_left: expected %0d, got %0d",
                               want.left, drv.speed_left);
                    end
                    if (drv.speed_right !== want.right)
                    begin
                        errors++;
                        $error("speed_right: expected %0d, got %0d",
                               want.right, drv.speed_right);
                    end
                end
                if (rx_run == 0)
                begin
                    rx_quiet = ($urandom_range(0, 2) == 0);
                    rx_run   = $urandom_range(10, 40);
                end
                rx_run--;
                rx_stall = rx_quiet ? 0 : $urandom_range(0, 10);
            end
            else if (rx_stall > 0)
            begin
                rx_stall--;
            end
            drv.ready <= (rx_stall == 0) && (hold_left == 0);
        end
    end

    // Counts out the long receiver hold-off in its own process.
    always @(posedge clk)
    begin
        if (hold_granted != hold_requests)
        begin
            hold_granted <= hold_requests;
            hold_left    <= LONG_HOLD;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // Ends the run if nothing moves on any port for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (smp.valid && smp.ready) || (drv.valid && drv.ready)
            || (psel && penable && pready))
        begin
            stuck_cycles <= 0;
        end
        else if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
        else
        begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial
    begin
        int                          ph;
        int                          n;
        int                          shift;
        logic [rnwc_pkg::RAW_W-1:0]  limit;

        // Known values on every input from time zero, and the shadow state
        // at its reset values.
        rst_n            = 1'b0;
        smp.valid        = 1'b0;
        smp.prox_0       = '0;
        smp.prox_1       = '0;
        smp.prox_2       = '0;
        smp.prox_3       = '0;
        smp.prox_4       = '0;
        smp.prox_5       = '0;
        smp.prox_6       = '0;
        smp.prox_7       = '0;
        smp.ground_left  = '0;
        smp.ground_right = '0;
        drv.ready        = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        for (n = 0; n < rnwc_pkg::WEIGHT_TOTAL; n++)
            weight_bank[n] = '0;
        ground_limit  = rnwc_pkg::THRESHOLD_RESET;
        prev_left     = '0;
        prev_right    = '0;
        errors        = 0;
        tx_item       = '0;
        tx_busy       = 1'b0;
        tx_gap        = 0;
        tx_run        = 0;
        tx_quiet      = 1'b0;
        rx_stall      = 0;
        rx_run        = 0;
        rx_quiet      = 1'b0;
        hold_requests = 0;
        hold_granted  = 0;
        hold_left     = 0;
        stuck_cycles  = 0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Straight out of reset all weights are zero, so every speed is zero
        // whatever the readings.  The ground pair straddles the reset
        // threshold of 800.
        pending_samples.push_back(uniform_sample(12'd0, 12'd0, 12'd0));
        pending_samples.push_back(uniform_sample(12'd4095, 12'd4095, 12'd4095));
        pending_samples.push_back(uniform_sample(12'd512, 12'd800, 12'd801));
        wait_drained();

        // All weights at the positive extreme: the sums run far past 5 and
        // clip.  With the threshold at full scale no ground reading can be
        // above it.
        write_all_weights({rnwc_pkg::WEIGHTS_PER_REG{16'h7FFF}});
        write_threshold(12'd4095);
        pending_samples.push_back(uniform_sample(12'd0, 12'd0, 12'd0));
        pending_samples.push_back(uniform_sample(12'd4095, 12'd4095, 12'd4095));
        pending_samples.push_back(uniform_sample(12'd512, 12'd4095, 12'd0));
        wait_drained();

        // Negative extreme, threshold zero.  A write to the register index
        // past the last one must change nothing.
        write_all_weights({rnwc_pkg::WEIGHTS_PER_REG{16'h8000}});
        write_threshold(12'd0);
        write_register(REG_UNUSED, {$urandom(), $urandom()});
        pending_samples.push_back(uniform_sample(12'd0, 12'd1, 12'd0));
        pending_samples.push_back(uniform_sample(12'd4095, 12'd0, 12'd1));
        pending_samples.push_back(uniform_sample(12'd600, 12'd4095, 12'd4095));
        wait_drained();

        // Small input weights with strong recurrent weights, so the previous
        // speeds dominate the next sums.  The first two samples put the
        // ground readings right at and just above the threshold.
        for (n = 0; n < int'(rnwc_pkg::REG_WEIGHTS_LAST); n++)
            write_register(n, random_weight_word(6));
        write_register(int'(rnwc_pkg::REG_WEIGHTS_LAST), random_weight_word(2));
        write_threshold(12'd2048);
        pending_samples.push_back(uniform_sample(12'd500, 12'd2048, 12'd2049));
        pending_samples.push_back(uniform_sample(12'd520, 12'd2049, 12'd2048));
        for (n = 0; n < 6; n++)
            pending_samples.push_back(random_sample());
        wait_drained();

        // Random phases.  Each one reloads every weight register at its own
        // scale; one phase uses full scale weights, where most sums clip.
        for (ph = 0; ph < PHASE_COUNT; ph++)
        begin
            shift = (ph == 5) ? 0 : 3 + ((ph * 3) % 8);
            for (n = 0; n <= int'(rnwc_pkg::REG_WEIGHTS_LAST); n++)
                write_register(n, random_weight_word(shift));
            if (ph == 1)
                limit = '0;
            else if (ph == 3)
                limit = rnwc_pkg::RAW_W'(RAW_MAX);
            else
                limit = rnwc_pkg::RAW_W'($urandom_range(0, RAW_MAX));
            write_threshold(limit);

            // In this phase the receiver holds off for a long stretch while
            // the sender keeps offering samples, so the pipeline fills and
            // the sample channel backs up.
            if (ph == 2)
                hold_requests++;

            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                // Halfway through this phase the sender stops until every
                // drive beat has come back, then carries on.
                if (ph == 4 && n == PHASE_ITEMS / 2)
                    wait_drained();
                pending_samples.push_back(random_sample());
            end
            wait_drained();
        end

        // Give a stray drive beat time to show up.
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_speeds.size() != 0)
        begin
            errors += expected_speeds.size();
            $error("%0d predicted drive beats never arrived", expected_speeds.size());
        end
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
